@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/olt_pkg.sv @@
// ----------------------------------------------------------------------------
// olt_pkg
// operation codes, status codes and the cell command type of the ordered list
// ----------------------------------------------------------------------------
package olt_pkg;

   // operation modes of a request transaction
   localparam logic [2:0] MODE_APPEND = 3'd0;
   localparam logic [2:0] MODE_INSERT = 3'd1;
   localparam logic [2:0] MODE_SORTED = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;

   // response status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // cell commands
   localparam logic [2:0] CMD_HOLD    = 3'd0;
   localparam logic [2:0] CMD_MARK    = 3'd1;
   localparam logic [2:0] CMD_SHIFT   = 3'd2;
   localparam logic [2:0] CMD_INSERT  = 3'd3;
   localparam logic [2:0] CMD_COMPACT = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic               del_sel;  // mark matches (delete) instead of greater
      logic               parity;   // pair phase of the compaction sweep
      logic signed [31:0] value;
   } cmd_type;

endpackage

@@ rtl/core/olt_cell.sv @@
// ----------------------------------------------------------------------------
// olt_cell
// one slot of the list: entry, hole flag for compaction, tap flag for the
// flag chain that drains toward slot zero
// ----------------------------------------------------------------------------
module olt_cell #(
   parameter int CAPACITY = 16,
   parameter int INDEX    = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  olt_pkg::cmd_type              cmd,
   input  logic [$clog2(CAPACITY)-1:0]   at,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   input  logic signed [31:0]            prev_entry,
   input  logic                          prev_hole,
   input  logic signed [31:0]            next_entry,
   input  logic                          next_hole,
   input  logic                          next_tap,
   output logic signed [31:0]            entry,
   output logic                          hole,
   output logic                          tap
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] IDX_AT  = IW'(INDEX);
   localparam logic [CW-1:0] IDX_CNT = CW'(INDEX);
   localparam logic          CELL_ODD = 1'(INDEX % 2);

   logic signed [31:0] entry_ff, entry_in;
   logic               hole_ff, hole_in;
   logic               tap_ff, tap_in;
   logic               in_use;
   logic               match;

   assign in_use = IDX_CNT < count;
   assign match  = entry_ff == cmd.value;

   always_comb begin
      entry_in = entry_ff;
      hole_in  = hole_ff;
      tap_in   = tap_ff;
      case (cmd.op)
         olt_pkg::CMD_MARK: begin
            tap_in  = in_use && (cmd.del_sel ? match : (entry_ff > cmd.value));
            hole_in = !in_use || match;
         end
         olt_pkg::CMD_SHIFT: begin
            tap_in = next_tap;
         end
         olt_pkg::CMD_INSERT: begin
            if (IDX_AT > at) begin
               entry_in = prev_entry;
            end else if (IDX_AT == at) begin
               entry_in = cmd.value;
            end
         end
         olt_pkg::CMD_COMPACT: begin
            tap_in = next_tap;
            // lower cell of a pair pulls a kept entry down over a hole
            if (CELL_ODD == cmd.parity) begin
               if (hole_ff && !next_hole) begin
                  entry_in = next_entry;
                  hole_in  = 1'b0;
               end
            end else begin
               if (prev_hole && !hole_ff) begin
                  entry_in = prev_entry;
                  hole_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         hole_ff <= 1'b1;
         tap_ff  <= 1'b0;
      end else begin
         hole_ff <= hole_in;
         tap_ff  <= tap_in;
      end
   end

   assign entry = entry_ff;
   assign hole  = hole_ff;
   assign tap   = tap_ff;

endmodule

@@ rtl/core/ordered_list_table.sv @@
// sequence: append, positional insert and read pass one working state; a dropped
//   insert or unused mode goes straight to the response; sorted insert marks, scans
//   to the insert slot, then inserts; delete marks, then compacts over all cells
// ordering: one transaction in flight; the next request is taken only after
//   the response of the one before is registered
// reset: synchronous, clears the count and all control; entries keep garbage
// ----------------------------------------------------------------------------
// ordered_list_table
// bounded ordered list of signed 32-bit values held in a row of shift cells
// ----------------------------------------------------------------------------
module ordered_list_table #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [4:0]         rsp_entry_count,
   output logic [4:0]         rsp_removed_count,
   output logic [1:0]         rsp_status
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
   localparam logic [CW-1:0] LAST_CNT = CW'(CAPACITY - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MARK    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_INSERT  = 3'd3;
   localparam logic [2:0] S_COMPACT = 3'd4;
   localparam logic [2:0] S_READ    = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;     // fill count
   logic [CW-1:0]      step_ff, step_in;       // scan index / compaction phase
   logic [IW-1:0]      at_ff, at_in;           // insert slot
   logic [2:0]         mode_ff, mode_in;
   logic signed [31:0] value_ff, value_in;
   logic [7:0]         pos_ff, pos_in;

   // result being built for the current transaction
   logic signed [31:0] res_read_ff, res_read_in;
   logic [CW-1:0]      res_removed_ff, res_removed_in;
   logic [1:0]         res_status_ff, res_status_in;

   // response output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_read_ff, rsp_read_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;
   logic [4:0]         rsp_removed_ff, rsp_removed_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   olt_pkg::cmd_type   cmd;

   // cell row outputs
   logic signed [31:0] entry_w [CAPACITY];
   logic               hole_w  [CAPACITY];
   logic               tap_w   [CAPACITY];

   logic               req_take;
   logic               is_insert;
   logic               rsp_free;
   logic               read_hit;

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign is_insert = req_mode == olt_pkg::MODE_APPEND || req_mode == olt_pkg::MODE_INSERT
                      || req_mode == olt_pkg::MODE_SORTED;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign read_hit  = {1'b0, pos_ff} < 9'(count_ff);

   // ---------------------------------------------------------------- cell row
   // each cell sees its lower and upper neighbor; the ends are tied so that
   // no entry moves past the row and the flag chain drains zeros in at the top
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] prev_entry, next_entry;
      logic               prev_hole, next_hole, next_tap;

      if (i == 0) begin : g_bottom
         assign prev_entry = '0;
         assign prev_hole  = 1'b0;
      end else begin : g_inner_lo
         assign prev_entry = entry_w[i-1];
         assign prev_hole  = hole_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign next_entry = '0;
         assign next_hole  = 1'b1;
         assign next_tap   = 1'b0;
      end else begin : g_inner_hi
         assign next_entry = entry_w[i+1];
         assign next_hole  = hole_w[i+1];
         assign next_tap   = tap_w[i+1];
      end

      olt_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .at         (at_ff),
         .count      (count_ff),
         .prev_entry (prev_entry),
         .prev_hole  (prev_hole),
         .next_entry (next_entry),
         .next_hole  (next_hole),
         .next_tap   (next_tap),
         .entry      (entry_w[i]),
         .hole       (hole_w[i]),
         .tap        (tap_w[i])
      );
   end

   // --------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      at_in          = at_ff;
      mode_in        = mode_ff;
      value_in       = value_ff;
      pos_in         = pos_ff;
      res_read_in    = res_read_ff;
      res_removed_in = res_removed_ff;
      res_status_in  = res_status_ff;

      cmd.op      = olt_pkg::CMD_HOLD;
      cmd.del_sel = mode_ff == olt_pkg::MODE_DELETE;
      cmd.parity  = step_ff[0];
      cmd.value   = value_ff;

      // response register drains independently of the sequencer
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_read_in    = rsp_read_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in        = req_mode;
               value_in       = req_value;
               pos_in         = req_position;
               step_in        = '0;
               res_read_in    = '0;
               res_removed_in = '0;
               res_status_in  = olt_pkg::ST_OK;
               if (is_insert && count_ff >= CAP_CNT) begin
                  // full list, insert dropped
                  res_status_in = olt_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  case (req_mode)
                     olt_pkg::MODE_APPEND: begin
                        at_in    = count_ff[IW-1:0];
                        state_in = S_INSERT;
                     end
                     olt_pkg::MODE_INSERT: begin
                        // position clamps to the tail
                        if (req_position < 8'(count_ff)) begin
                           at_in = req_position[IW-1:0];
                        end else begin
                           at_in = count_ff[IW-1:0];
                        end
                        state_in = S_INSERT;
                     end
                     olt_pkg::MODE_SORTED: state_in = S_MARK;
                     olt_pkg::MODE_DELETE: state_in = S_MARK;
                     olt_pkg::MODE_READ:   state_in = S_READ;
                     default:              state_in = S_DONE;
                  endcase
               end
            end
         end

         S_MARK: begin
            // every cell compares against the value at once
            cmd.op   = olt_pkg::CMD_MARK;
            step_in  = '0;
            state_in = (mode_ff == olt_pkg::MODE_DELETE) ? S_COMPACT : S_SCAN;
         end

         S_SCAN: begin
            // greater-than flags drain into slot zero one per cycle; the
            // first greater entry, or the tail, is the insert slot
            if (tap_w[0] || step_ff == count_ff) begin
               at_in    = step_ff[IW-1:0];
               state_in = S_INSERT;
            end else begin
               cmd.op  = olt_pkg::CMD_SHIFT;
               step_in = step_ff + CW'(1);
            end
         end

         S_INSERT: begin
            // cells at and above the slot move up one place
            cmd.op   = olt_pkg::CMD_INSERT;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end

         S_COMPACT: begin
            // odd-even transposition of holes toward the top; match flags
            // drain into slot zero at the same time and are counted there
            cmd.op         = olt_pkg::CMD_COMPACT;
            res_removed_in = res_removed_ff + CW'(tap_w[0]);
            step_in        = step_ff + CW'(1);
            if (step_ff == LAST_CNT) begin
               count_in = count_ff - res_removed_ff - CW'(tap_w[0]);
               state_in = S_DONE;
            end
         end

         S_READ: begin
            if (read_hit) begin
               res_read_in = entry_w[pos_ff[IW-1:0]];
            end else begin
               res_status_in = olt_pkg::ST_RANGE;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_read_in    = res_read_ff;
               rsp_count_in   = 5'(count_ff);
               rsp_removed_in = 5'(res_removed_ff);
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload, no reset needed
   always_ff @(posedge clock) begin
      at_ff          <= at_in;
      mode_ff        <= mode_in;
      value_ff       <= value_in;
      pos_ff         <= pos_in;
      res_read_ff    <= res_read_in;
      res_removed_ff <= res_removed_in;
      res_status_ff  <= res_status_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_read_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

@@ rtl/core/olt_checker.sv @@
// ----------------------------------------------------------------------------
// olt_checker
// port-level checks on the ordered list, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olt_checker #(
   parameter int CAPACITY = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_mode,
   input logic signed [31:0] req_value,
   input logic [7:0]         req_position,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_read_value,
   input logic [4:0]         rsp_entry_count,
   input logic [4:0]         rsp_removed_count,
   input logic [1:0]         rsp_status
);

   logic req_take;
   logic req_known;

   assign req_take  = req_valid && !req_stall;
   assign req_known = req_mode <= olt_pkg::MODE_READ || req_value == req_value
                      || req_position == req_position;

   // one transaction at a time: busy right after a request is taken
   `ASSERT_NEXT(a_busy_after_take, req_take && req_known, req_stall)

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_entry_count) && $stable(rsp_status))

   // a removal only comes from a plain delete
   `ASSERT_SAME(a_removed_ok, rsp_valid && rsp_removed_count != 5'd0,
      rsp_status == olt_pkg::ST_OK && rsp_read_value == 32'sd0)

   // a dropped insert reports a full list
   `ASSERT_SAME(a_full_count, rsp_valid && rsp_status == olt_pkg::ST_FULL,
      rsp_entry_count == 5'(CAPACITY) && rsp_removed_count == 5'd0)

endmodule

bind ordered_list_table olt_checker #(.CAPACITY(CAPACITY)) u_olt_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// ordered list table: directed and random insert, delete and read traffic,
// every response checked field by field against a shadow copy of the list
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = 16;
   // slowest legal gap between handshakes (long hold-off, full compaction sweep,
   // longest sender gap) is far below this, so this leaves a wide margin
   localparam int IDLE_LIMIT  = 2000;
   // settle time after the last response, longer than a full delete
   localparam int SETTLE_WAIT = CAPACITY + 8;
   localparam int RANDOM_OPS  = 1850;
   localparam int HOLDOFF_LEN = 80;

   // mode codes the block does not use, it must answer with the count only
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   // traffic tendencies of one burst
   localparam int LEAN_GROW   = 0;
   localparam int LEAN_SHRINK = 1;
   localparam int LEAN_MIXED  = 2;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [4:0]         entry_count;
      logic [4:0]         removed_count;
      logic [1:0]         status;
   } list_outcome_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic signed [31:0] req_value;
   logic [7:0]         req_position;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_read_value;
   logic [4:0]         rsp_entry_count;
   logic [4:0]         rsp_removed_count;
   logic [1:0]         rsp_status;

   // shadow copy of the list, advanced at each accepted request transaction
   logic signed [31:0] list_shadow [CAPACITY];
   int                 list_fill;
   // outcomes still owed by the block, oldest first
   list_outcome_type   pending_outcomes [$];
   int                 failure_count;
   // long receiver hold-off requested by a test, taken up by the stall process
   int                 holdoff_request;

   ordered_list_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_removed_count(rsp_removed_count),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // list behavior: apply one operation to the shadow list, return the outcome
   // ------------------------------------------------------------------------
   function automatic list_outcome_type apply_list_op(input logic [2:0] mode,
                                                      input logic signed [31:0] value,
                                                      input logic [7:0] position);
      list_outcome_type outcome;
      int               slot;
      int               idx;
      int               kept;
      int               removed;
      logic             adds_entry;
      outcome    = '0;
      removed    = 0;
      adds_entry = (mode == olt_pkg::MODE_APPEND) || (mode == olt_pkg::MODE_INSERT)
                   || (mode == olt_pkg::MODE_SORTED);
      if (adds_entry && list_fill >= CAPACITY) begin
         // full list, the insert is dropped
         outcome.status = olt_pkg::ST_FULL;
      end else begin
         case (mode)
            olt_pkg::MODE_APPEND, olt_pkg::MODE_INSERT, olt_pkg::MODE_SORTED: begin
               if (mode == olt_pkg::MODE_APPEND) begin
                  slot = list_fill;
               end else if (mode == olt_pkg::MODE_INSERT) begin
                  // position past the tail clamps to the tail
                  slot = (position < list_fill) ? int'(position) : list_fill;
               end else begin
                  // land after every entry not greater than the value
                  slot = 0;
                  while (slot < list_fill && list_shadow[slot] <= value) slot++;
               end
               for (idx = list_fill; idx > slot; idx--) list_shadow[idx] = list_shadow[idx - 1];
               list_shadow[slot] = value;
               list_fill++;
            end
            olt_pkg::MODE_DELETE: begin
               // drop every equal entry and close the gaps in order
               kept = 0;
               for (idx = 0; idx < list_fill; idx++) begin
                  if (list_shadow[idx] == value) begin
                     removed++;
                  end else begin
                     list_shadow[kept] = list_shadow[idx];
                     kept++;
                  end
               end
               list_fill = kept;
            end
            olt_pkg::MODE_READ: begin
               if (position < list_fill) begin
                  outcome.read_value = list_shadow[position];
               end else begin
                  outcome.status = olt_pkg::ST_RANGE;
               end
            end
            default: begin
               // spare modes leave everything alone
            end
         endcase
      end
      outcome.entry_count   = list_fill[4:0];
      outcome.removed_count = removed[4:0];
      return outcome;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one request transaction and hold it until the block takes it;
   // valid stays high into the next call so back-to-back items need no gap
   task automatic send_op(input logic [2:0] mode, input logic signed [31:0] value,
                          input logic [7:0] position);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.push_back(apply_list_op(mode, value, position));
   endtask

   // idle the request side, with junk on the payload the block must ignore
   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid    <= 1'b0;
         req_mode     <= 3'($urandom);
         req_value    <= $urandom;
         req_position <= 8'($urandom);
      end
   endtask

   task automatic wait_all_results();
      pause_sender(1);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // value: small pool for duplicates, live entries for hits, extremes, noise
   function automatic logic signed [31:0] pick_value(input int favor_live);
      int roll;
      roll = $urandom_range(0, 9);
      if (list_fill > 0 && roll < favor_live) begin
         return list_shadow[$urandom_range(0, list_fill - 1)];
      end
      case ($urandom_range(0, 5))
         0, 1:    return $urandom_range(0, 6) - 3;
         2: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MIN;
               1:       return VALUE_MAX;
               2:       return -1;
               default: return 0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // one random operation shaped by the tendency of the current burst
   task automatic pick_op(input int lean, output logic [2:0] mode,
                          output logic signed [31:0] value, output logic [7:0] position);
      int cut [5];
      int roll;
      case (lean)
         LEAN_GROW:   cut = '{25, 50, 80, 85, 95};
         LEAN_SHRINK: cut = '{5, 10, 20, 65, 95};
         default:     cut = '{15, 30, 50, 70, 95};
      endcase
      roll = $urandom_range(0, 99);
      if (roll < cut[0])      mode = olt_pkg::MODE_APPEND;
      else if (roll < cut[1]) mode = olt_pkg::MODE_INSERT;
      else if (roll < cut[2]) mode = olt_pkg::MODE_SORTED;
      else if (roll < cut[3]) mode = olt_pkg::MODE_DELETE;
      else if (roll < cut[4]) mode = olt_pkg::MODE_READ;
      else                    mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      value = pick_value((mode == olt_pkg::MODE_DELETE) ? 6 : 2);
      roll  = $urandom_range(0, 9);
      if (roll < 6)      position = 8'($urandom_range(0, list_fill));
      else if (roll < 8) position = 8'(list_fill + $urandom_range(0, 2));
      else               position = 8'($urandom_range(0, 255));
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   // stall pattern: randomly chosen styles in turn, plus a long
   // hold-off on request so the block fills up and stalls its input
   initial begin : response_stall_pattern
      int style;
      int style_left;
      int holdoff_left;
      rsp_stall    = 1'b0;
      style        = 0;
      style_left   = 0;
      holdoff_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left > 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 3);
               style_left = $urandom_range(10, 60);
            end
            style_left--;
            case (style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 7) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // compare each response transaction with the oldest pending outcome
   always @(posedge clock) begin : response_check
      list_outcome_type awaited;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            failure_count++;
            if (failure_count <= 10) begin
               $display("%0t: response with nothing pending: read %0d count %0d removed %0d status %0d",
                        $realtime, rsp_read_value, rsp_entry_count, rsp_removed_count,
                        rsp_status);
            end
         end else begin
            awaited = pending_outcomes.pop_front();
            if (rsp_read_value !== awaited.read_value || rsp_entry_count !== awaited.entry_count
                || rsp_removed_count !== awaited.removed_count
                || rsp_status !== awaited.status) begin
               failure_count++;
               if (failure_count <= 10) begin
                  $display("%0t: mismatch read %0d/%0d count %0d/%0d removed %0d/%0d status %0d/%0d",
                           $realtime, awaited.read_value, rsp_read_value,
                           awaited.entry_count, rsp_entry_count, awaited.removed_count,
                           rsp_removed_count, awaited.status, rsp_status);
                  $display("   (expected/actual)");
               end
            end
         end
      end
   end

   // end the run when neither channel moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // extremes, every mode, clamping, out of range reads, delete with no match
   task automatic test_basic_ops();
      send_op(olt_pkg::MODE_READ, 0, 8'd0);               // read of an empty list
      send_op(olt_pkg::MODE_INSERT, VALUE_MAX, 8'd255);   // insert into empty becomes append
      send_op(olt_pkg::MODE_APPEND, VALUE_MIN, 8'd0);
      send_op(olt_pkg::MODE_SORTED, 0, 8'd0);
      send_op(olt_pkg::MODE_INSERT, -1, 8'd1);
      send_op(olt_pkg::MODE_READ, 0, 8'd3);
      send_op(olt_pkg::MODE_READ, 0, 8'd200);             // index past the count
      send_op(MODE_SPARE_FIRST, $urandom, 8'($urandom));
      send_op(MODE_SPARE_LAST, $urandom, 8'($urandom));
      send_op(olt_pkg::MODE_DELETE, 99, 8'd0);            // no match
      send_op(olt_pkg::MODE_DELETE, VALUE_MIN, 8'd0);
   endtask

   // fill to capacity, bounce every insert kind off it, then delete the filler entries
   task automatic test_full_list();
      while (list_fill < CAPACITY) send_op(olt_pkg::MODE_APPEND, 42, 8'd0);
      send_op(olt_pkg::MODE_APPEND, 1, 8'd0);
      send_op(olt_pkg::MODE_INSERT, 2, 8'd0);
      send_op(olt_pkg::MODE_SORTED, 3, 8'd0);
      send_op(olt_pkg::MODE_READ, 0, 8'(CAPACITY - 1));
      send_op(olt_pkg::MODE_DELETE, 42, 8'd0);
   endtask

   // long receiver hold-off while requests keep coming, input must stall
   task automatic test_backpressure();
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         position;
      holdoff_request = HOLDOFF_LEN;
      repeat (10) begin
         pick_op(LEAN_GROW, mode, value, position);
         send_op(mode, value, position);
      end
   endtask

   // sender goes quiet until every response is back, then resumes
   task automatic test_drain_pause();
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         position;
      repeat (2) begin
         repeat (8) begin
            pick_op(LEAN_MIXED, mode, value, position);
            send_op(mode, value, position);
         end
         wait_all_results();
      end
   endtask

   // bursts of well-formed traffic leaning toward growth or shrinkage, so the
   // list swings between empty and full, with random gaps or none between bursts
   task automatic test_random_mix(input int op_total);
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         position;
      int                 sent;
      int                 burst;
      int                 lean;
      sent = 0;
      while (sent < op_total) begin
         burst = $urandom_range(1, 20);
         lean  = $urandom_range(LEAN_GROW, LEAN_MIXED);
         while (burst > 0 && sent < op_total) begin
            pick_op(lean, mode, value, position);
            send_op(mode, value, position);
            sent++;
            burst--;
         end
         case ($urandom_range(0, 7))
            0, 1, 2: ;                                      // straight into the next burst
            3, 4, 5: pause_sender($urandom_range(1, 4));
            6:       pause_sender($urandom_range(5, 25));
            default: wait_all_results();
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = olt_pkg::MODE_APPEND;
      req_value       = '0;
      req_position    = '0;
      list_fill       = 0;
      failure_count   = 0;
      holdoff_request = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_full_list();
      test_backpressure();
      test_drain_pause();
      test_random_mix(RANDOM_OPS);

      wait_all_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (failure_count == 0 && pending_outcomes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
